// File: hw/rtl/imm_pkg.sv
`default_nettype none
package imm_pkg;

	localparam int unsigned DEF_MAX_ROWS  = 8;
	localparam int unsigned DEF_MAX_INNER = 8;
	localparam int unsigned DEF_MAX_COLS  = 8;

	localparam int unsigned SIZE_W  = 4;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned COORD_W = 3;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS_A     = 2'd0;
	localparam logic [1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [1:0] REG_COLS_B     = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input int unsigned maxv);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (int'(v) > int'(maxv)) begin
			r = SIZE_W'(maxv);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/imm_cmd_if.sv
`default_nettype none
interface imm_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [imm_pkg::CMD_W-1:0]           command;
	logic [imm_pkg::COORD_W-1:0]         row_index;
	logic [imm_pkg::COORD_W-1:0]         col_index;
	logic signed [imm_pkg::DATA_W-1:0]   element_value;

	modport source (output valid, command, row_index, col_index, element_value, input ready);
	modport sink (input valid, command, row_index, col_index, element_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/imm_res_if.sv
`default_nettype none
interface imm_res_if;
	logic                                valid;
	logic                                ready;
	logic [imm_pkg::COORD_W-1:0]         out_row;
	logic [imm_pkg::COORD_W-1:0]         out_col;
	logic signed [imm_pkg::DATA_W-1:0]   product_value;
	logic                                last;

	modport source (output valid, out_row, out_col, product_value, last, input ready);
	modport sink (input valid, out_row, out_col, product_value, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/integer_matrix_multiply.sv
// Loads of A or B keep the block in IDLE; the block is ready again on the next cycle.
// A compute walks one multiply-accumulate per cycle while in ISSUE through a shared 32x32 multiplier:
// each result element issues its n products in ISSUE, waits in DRAIN for the read and multiply
// stages to empty and is sent in WRITE, so a compute holds the input until its final beat is
// registered, plus output stalls; the final beat may wait while new items are taken.
// Asynchronous active-low reset clears control, sets the size registers to 8; stores keep data.
`default_nettype none
module integer_matrix_multiply #(
	parameter int unsigned MAX_ROWS  = imm_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_INNER = imm_pkg::DEF_MAX_INNER,
	parameter int unsigned MAX_COLS  = imm_pkg::DEF_MAX_COLS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [imm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [imm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [imm_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	imm_cmd_if.sink                           cmd,
	imm_res_if.source                         res
);

	localparam int unsigned A_DEPTH = MAX_ROWS * MAX_INNER;
	localparam int unsigned B_DEPTH = MAX_INNER * MAX_COLS;
	localparam int unsigned A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int unsigned B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
	localparam int unsigned SW      = imm_pkg::SIZE_W;
	localparam int unsigned DW      = imm_pkg::DATA_W;

	typedef enum logic [1:0] {IDLE, ISSUE, DRAIN, WRITE} state_t;

	state_t state_q;

	logic [SW-1:0] rows_a_q, inner_size_q, cols_b_q;
	logic [SW-1:0] m_eff, n_eff, p_eff;
	logic [SW-1:0] i_q, j_q, k_q;

	logic [DW-1:0] mem_a [A_DEPTH];
	logic [DW-1:0] mem_b [B_DEPTH];
	logic [DW-1:0] a_rd_s1, b_rd_s1, prod_s2, acc_q;
	logic          rd_v_s1, mul_v_s2;

	logic            cmd_fire, cfg_we, out_free, last_elem, acc_clr;
	logic            a_we, b_we;
	logic [A_AW-1:0] a_waddr, a_raddr;
	logic [B_AW-1:0] b_waddr, b_raddr;
	logic [1:0]      reg_idx;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[3:2];
	assign cfg_we   = psel && penable && pwrite;

	assign m_eff = imm_pkg::clamp_size(rows_a_q, MAX_ROWS);
	assign n_eff = imm_pkg::clamp_size(inner_size_q, MAX_INNER);
	assign p_eff = imm_pkg::clamp_size(cols_b_q, MAX_COLS);

	assign cmd.ready = (state_q == IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign out_free  = !res.valid || res.ready;
	assign last_elem = (i_q == m_eff - SW'(1)) && (j_q == p_eff - SW'(1));
	assign acc_clr   = (cmd_fire && cmd.command == imm_pkg::CMD_COMPUTE) ||
		(state_q == WRITE && out_free);

	assign a_we = cmd_fire && cmd.command == imm_pkg::CMD_WRITE_A &&
		({1'b0, cmd.row_index} < m_eff) && ({1'b0, cmd.col_index} < n_eff);
	assign b_we = cmd_fire && cmd.command == imm_pkg::CMD_WRITE_B &&
		({1'b0, cmd.row_index} < n_eff) && ({1'b0, cmd.col_index} < p_eff);

	assign a_waddr = A_AW'(int'(cmd.row_index) * MAX_INNER + int'(cmd.col_index));
	assign b_waddr = B_AW'(int'(cmd.row_index) * MAX_COLS + int'(cmd.col_index));
	assign a_raddr = A_AW'(int'(i_q) * MAX_INNER + int'(k_q));
	assign b_raddr = B_AW'(int'(k_q) * MAX_COLS + int'(j_q));

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			imm_pkg::REG_ROWS_A:     prdata = {{(imm_pkg::PDATA_W-SW){1'b0}}, rows_a_q};
			imm_pkg::REG_INNER_SIZE: prdata = {{(imm_pkg::PDATA_W-SW){1'b0}}, inner_size_q};
			imm_pkg::REG_COLS_B:     prdata = {{(imm_pkg::PDATA_W-SW){1'b0}}, cols_b_q};
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= imm_pkg::SIZE_RESET;
			inner_size_q <= imm_pkg::SIZE_RESET;
			cols_b_q     <= imm_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx)
				imm_pkg::REG_ROWS_A:     rows_a_q     <= pwdata[SW-1:0];
				imm_pkg::REG_INNER_SIZE: inner_size_q <= pwdata[SW-1:0];
				imm_pkg::REG_COLS_B:     cols_b_q     <= pwdata[SW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[a_waddr] <= cmd.element_value;
		end
		a_rd_s1 <= mem_a[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			mem_b[b_waddr] <= cmd.element_value;
		end
		b_rd_s1 <= mem_b[b_raddr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (acc_clr) begin
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= IDLE;
			i_q               <= '0;
			j_q               <= '0;
			k_q               <= '0;
			rd_v_s1           <= 1'b0;
			mul_v_s2          <= 1'b0;
			res.valid         <= 1'b0;
			res.out_row       <= '0;
			res.out_col       <= '0;
			res.product_value <= '0;
			res.last          <= 1'b0;
		end else begin
			rd_v_s1  <= (state_q == ISSUE);
			mul_v_s2 <= rd_v_s1;
			if (res.ready && !(state_q == WRITE && out_free)) begin
				res.valid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (cmd_fire && cmd.command == imm_pkg::CMD_COMPUTE) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ISSUE;
					end
				end
				ISSUE: begin
					if (k_q == n_eff - SW'(1)) begin
						state_q <= DRAIN;
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				DRAIN: begin
					if (!rd_v_s1 && !mul_v_s2) begin
						state_q <= WRITE;
					end
				end
				WRITE: begin
					if (out_free) begin
						res.valid         <= 1'b1;
						res.out_row       <= i_q[imm_pkg::COORD_W-1:0];
						res.out_col       <= j_q[imm_pkg::COORD_W-1:0];
						res.product_value <= acc_q;
						res.last          <= last_elem;
						k_q               <= '0;
						if (last_elem) begin
							state_q <= IDLE;
						end else begin
							state_q <= ISSUE;
							if (j_q == p_eff - SW'(1)) begin
								j_q <= '0;
								i_q <= i_q + SW'(1);
							end else begin
								j_q <= j_q + SW'(1);
							end
						end
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/imm_checker.sv
`default_nettype none
module imm_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             cmd_valid,
	input wire logic                             cmd_ready,
	input wire logic [imm_pkg::CMD_W-1:0]        cmd_command,
	input wire logic                             res_valid,
	input wire logic                             res_ready,
	input wire logic                             res_last,
	input wire logic [imm_pkg::DATA_W-1:0]       res_product_value
);

	logic cmd_beat;
	assign cmd_beat = cmd_valid && cmd_ready;

	a_compute_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_beat && cmd_command == imm_pkg::CMD_COMPUTE |=> !cmd_ready)
		else $error("input still ready after a compute beat");

	a_load_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_beat && cmd_command != imm_pkg::CMD_COMPUTE |=> cmd_ready)
		else $error("input not ready after a load beat");

	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) && !res_last |-> !cmd_ready)
		else $error("input ready while a compute is still producing results");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_product_value))
		else $error("stalled result beat changed");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.cmd_command       (cmd.command),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_last          (res.last),
	.res_product_value (res.product_value)
);
`default_nettype wire

// File: dv/imm_product_check.sv
module imm_product_check (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [imm_pkg::PADDR_W-1:0] paddr,
	input  wire logic [imm_pkg::PDATA_W-1:0] pwdata,
	imm_cmd_if                               cmd_mon,
	imm_res_if                               res_mon,
	output int                               errors,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import imm_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [DATA_W-1:0]  value;
		logic               last;
	} product_t;

	product_t          product_queue[$];
	logic [DATA_W-1:0] a_words[DEF_MAX_ROWS*DEF_MAX_INNER];
	logic [DATA_W-1:0] b_words[DEF_MAX_INNER*DEF_MAX_COLS];
	logic [SIZE_W-1:0] rows_reg;
	logic [SIZE_W-1:0] inner_reg;
	logic [SIZE_W-1:0] cols_reg;

	function automatic int unsigned span(input logic [SIZE_W-1:0] v, input int unsigned maxv);
		if (v == 0) begin
			return 1;
		end
		if (v > maxv) begin
			return maxv;
		end
		return v;
	endfunction

	task automatic apply_command(input logic [CMD_W-1:0] op, input logic [COORD_W-1:0] r,
		input logic [COORD_W-1:0] c, input logic [DATA_W-1:0] v);
		int unsigned m;
		int unsigned n;
		int unsigned p;
		logic [DATA_W-1:0] acc;
		product_t item;
		m = span(rows_reg, DEF_MAX_ROWS);
		n = span(inner_reg, DEF_MAX_INNER);
		p = span(cols_reg, DEF_MAX_COLS);
		case (op)
			CMD_WRITE_A: begin
				if (r < m && c < n) begin
					a_words[r*DEF_MAX_INNER+c] = v;
				end
			end
			CMD_WRITE_B: begin
				if (r < n && c < p) begin
					b_words[r*DEF_MAX_COLS+c] = v;
				end
			end
			CMD_COMPUTE: begin
				for (int unsigned i = 0; i < m; i++) begin
					for (int unsigned j = 0; j < p; j++) begin
						acc = '0;
						for (int unsigned k = 0; k < n; k++) begin
							acc = acc + a_words[i*DEF_MAX_INNER+k] * b_words[k*DEF_MAX_COLS+j];
						end
						item.row = COORD_W'(i);
						item.col = COORD_W'(j);
						item.value = acc;
						item.last = (i + 1 == m) && (j + 1 == p);
						product_queue.push_back(item);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		product_t want;
		if (!arst_n) begin
			rows_reg = SIZE_RESET;
			inner_reg = SIZE_RESET;
			cols_reg = SIZE_RESET;
			product_queue.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				if (product_queue.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected beat: row %0d col %0d value %0d last %0b",
							res_mon.out_row, res_mon.out_col, res_mon.product_value,
							res_mon.last);
					end
				end else begin
					want = product_queue.pop_front();
					if (res_mon.out_row !== want.row || res_mon.out_col !== want.col ||
						res_mon.product_value !== want.value || res_mon.last !== want.last) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: expected row %0d col %0d value %0d last %0b",
								want.row, want.col, $signed(want.value), want.last);
							$display("          actual   row %0d col %0d value %0d last %0b",
								res_mon.out_row, res_mon.out_col, res_mon.product_value,
								res_mon.last);
						end
					end
				end
			end
			if (cmd_mon.valid && cmd_mon.ready) begin
				apply_command(cmd_mon.command, cmd_mon.row_index, cmd_mon.col_index,
					cmd_mon.element_value);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_ROWS_A: rows_reg = pwdata[SIZE_W-1:0];
					REG_INNER_SIZE: inner_reg = pwdata[SIZE_W-1:0];
					REG_COLS_B: cols_reg = pwdata[SIZE_W-1:0];
					default: begin
					end
				endcase
			end
			pending = product_queue.size();
		end
	end
endmodule

// File: dv/integer_matrix_multiply_tb.sv
module integer_matrix_multiply_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import imm_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;
	localparam int TARGET_ITEMS = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	int                   errors;
	int                   pending;
	int                   quiet_cycles;
	int                   stall_left;
	int                   counted;
	bit                   steady;
	bit                   a_loaded[DEF_MAX_ROWS*DEF_MAX_INNER];
	bit                   b_loaded[DEF_MAX_INNER*DEF_MAX_COLS];
	int unsigned          eff_m;
	int unsigned          eff_n;
	int unsigned          eff_p;

	imm_cmd_if cmd_bus ();
	imm_res_if res_bus ();

	integer_matrix_multiply uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_bus),
		.res     (res_bus)
	);

	imm_product_check product_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.cmd_mon (cmd_bus),
		.res_mon (res_bus),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned active_size(input logic [SIZE_W-1:0] v,
		input int unsigned maxv);
		if (v == 0) begin
			return 1;
		end
		if (v > maxv) begin
			return maxv;
		end
		return v;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(5, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			4: return 32'($urandom_range(0, 31) - 16);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 15))
			0: return 4'd0;
			1: return SIZE_W'($urandom_range(9, 15));
			2: return 4'd8;
			default: return SIZE_W'($urandom_range(1, 4));
		endcase
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_bus.ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			stall_left <= rand_gap() - 1;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
			(psel && penable) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [SIZE_W-1:0] size);
		logic [PDATA_W-1:0] noise;
		noise = $urandom();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {noise[PDATA_W-1:SIZE_W], size};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_sizes(input logic [SIZE_W-1:0] m, input logic [SIZE_W-1:0] n,
		input logic [SIZE_W-1:0] p);
		reg_write(REG_ROWS_A, m);
		reg_write(REG_INNER_SIZE, n);
		reg_write(REG_COLS_B, p);
		eff_m = active_size(m, DEF_MAX_ROWS);
		eff_n = active_size(n, DEF_MAX_INNER);
		eff_p = active_size(p, DEF_MAX_COLS);
	endtask

	task automatic send_item(input logic [CMD_W-1:0] op, input logic [COORD_W-1:0] r,
		input logic [COORD_W-1:0] c, input logic [DATA_W-1:0] v);
		int gap;
		gap = (steady || $urandom_range(0, 1) == 0) ? 0 : rand_gap();
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.command <= op;
		cmd_bus.row_index <= r;
		cmd_bus.col_index <= c;
		cmd_bus.element_value <= v;
		do @(posedge clk); while (!cmd_bus.ready);
	endtask

	task automatic load(input logic [CMD_W-1:0] op, input logic [COORD_W-1:0] r,
		input logic [COORD_W-1:0] c, input logic [DATA_W-1:0] v);
		send_item(op, r, c, v);
		if (op == CMD_WRITE_A && r < eff_m && c < eff_n) begin
			a_loaded[r*DEF_MAX_INNER+c] = 1'b1;
			counted++;
		end else if (op == CMD_WRITE_B && r < eff_n && c < eff_p) begin
			b_loaded[r*DEF_MAX_COLS+c] = 1'b1;
			counted++;
		end
	endtask

	// fill every element the product will read before issuing it
	task automatic compute();
		for (int unsigned i = 0; i < eff_m; i++) begin
			for (int unsigned k = 0; k < eff_n; k++) begin
				if (!a_loaded[i*DEF_MAX_INNER+k]) begin
					load(CMD_WRITE_A, COORD_W'(i), COORD_W'(k), pick_value());
				end
			end
		end
		for (int unsigned k = 0; k < eff_n; k++) begin
			for (int unsigned j = 0; j < eff_p; j++) begin
				if (!b_loaded[k*DEF_MAX_COLS+j]) begin
					load(CMD_WRITE_B, COORD_W'(k), COORD_W'(j), pick_value());
				end
			end
		end
		send_item(CMD_COMPUTE, COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
		counted++;
	endtask

	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int nloads;
		int kind;
		logic [CMD_W-1:0] op;
		logic [SIZE_W-1:0] sm;
		logic [SIZE_W-1:0] sn;
		logic [SIZE_W-1:0] sp;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_WRITE_A;
		cmd_bus.row_index = '0;
		cmd_bus.col_index = '0;
		cmd_bus.element_value = '0;
		res_bus.ready = 1'b0;
		stall_left = 0;
		quiet_cycles = 0;
		counted = 0;
		steady = 1'b0;
		eff_m = DEF_MAX_ROWS;
		eff_n = DEF_MAX_INNER;
		eff_p = DEF_MAX_COLS;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_sizes(4'd2, 4'd3, 4'd2);
		load(CMD_WRITE_A, 3'd0, 3'd0, 32'h8000_0000);
		load(CMD_WRITE_A, 3'd0, 3'd1, 32'h7fff_ffff);
		load(CMD_WRITE_A, 3'd0, 3'd2, 32'hffff_ffff);
		load(CMD_WRITE_A, 3'd1, 3'd0, 32'h0000_0000);
		load(CMD_WRITE_A, 3'd1, 3'd1, 32'h0000_0001);
		load(CMD_WRITE_A, 3'd1, 3'd2, 32'h8000_0000);
		load(CMD_WRITE_B, 3'd0, 3'd0, 32'h8000_0000);
		load(CMD_WRITE_B, 3'd0, 3'd1, 32'hffff_ffff);
		load(CMD_WRITE_B, 3'd1, 3'd0, 32'h7fff_ffff);
		load(CMD_WRITE_B, 3'd1, 3'd1, 32'h7fff_ffff);
		load(CMD_WRITE_B, 3'd2, 3'd0, 32'hffff_ffff);
		load(CMD_WRITE_B, 3'd2, 3'd1, 32'h0000_0001);
		// out-of-range coordinates and the spare opcode must leave the stores alone
		load(CMD_WRITE_A, 3'd2, 3'd0, 32'h1234_5678);
		load(CMD_WRITE_A, 3'd0, 3'd3, 32'h5555_aaaa);
		load(CMD_WRITE_B, 3'd3, 3'd0, 32'haaaa_5555);
		load(CMD_WRITE_B, 3'd0, 3'd2, 32'hdead_beef);
		load(CMD_WRITE_A, 3'd7, 3'd7, 32'hffff_ffff);
		send_item(CMD_UNUSED, 3'd7, 3'd7, 32'hffff_ffff);
		compute();
		wait_idle();
		set_sizes(4'd0, 4'd0, 4'd0);
		compute();

		while (counted < TARGET_ITEMS) begin
			wait_idle();
			steady = ($urandom_range(0, 3) == 0);
			if (counted < 40) begin
				sm = 4'd15;
				sn = 4'd15;
				sp = 4'd15;
			end else begin
				sm = rand_size();
				sn = rand_size();
				sp = rand_size();
			end
			set_sizes(sm, sn, sp);
			nloads = $urandom_range(2, 16);
			repeat (nloads) begin
				kind = $urandom_range(0, 9);
				op = ($urandom_range(0, 1) == 0) ? CMD_WRITE_A : CMD_WRITE_B;
				if (kind == 0) begin
					send_item(CMD_UNUSED, COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
				end else if (kind == 1) begin
					load(op, COORD_W'($urandom()), COORD_W'($urandom()), pick_value());
				end else if (op == CMD_WRITE_A) begin
					load(op, COORD_W'($urandom_range(0, eff_m - 1)),
						COORD_W'($urandom_range(0, eff_n - 1)), pick_value());
				end else begin
					load(op, COORD_W'($urandom_range(0, eff_n - 1)),
						COORD_W'($urandom_range(0, eff_p - 1)), pick_value());
				end
			end
			repeat ($urandom_range(1, 2)) compute();
		end

		steady = 1'b0;
		wait_idle();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
